[hdl/wrg_pkg.sv]
// ----------------------------------------------------------------------------
// Windowed ramp generator package
// Shared types and constants: register indexes, configuration record,
// sequencer states and divider status.
// ----------------------------------------------------------------------------
package wrg_pkg;

    localparam int CODE_W   = 12;
    localparam int SAMP_W   = 15;
    localparam int CFG_IDX_W = 3;
    localparam int Q_W      = CODE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE           = 3'd0,
        REG_MIN_CODE       = 3'd1,
        REG_MAX_CODE       = 3'd2,
        REG_IDLE_CODE      = 3'd3,
        REG_HIGH_IDLE_CODE = 3'd4,
        REG_BAND_WIDTH     = 3'd5,
        REG_WINDOW_SAMPLES = 3'd6,
        REG_FRAME_SAMPLES  = 3'd7
    } cfg_reg_t;

    localparam logic MODE_IDLE_CODE = 1'b0;
    localparam logic MODE_BANDS     = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [CODE_W-1:0] min_code;
        logic [CODE_W-1:0] max_code;
        logic [CODE_W-1:0] idle_code;
        logic [CODE_W-1:0] high_idle_code;
        logic [CODE_W-1:0] band_width;
        logic [SAMP_W-1:0] window_samples;
        logic [SAMP_W-1:0] frame_samples;
    } wrg_cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_HOLD
    } wrg_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } wrg_div_stat_t;

endpackage

[hdl/wrg_if.sv]
// ----------------------------------------------------------------------------
// Windowed ramp generator channel interfaces
// Valid/ready channels for the sample tick input and the code output.
// ----------------------------------------------------------------------------
interface wrg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface wrg_out_if import wrg_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] dac_code;
    logic              frame_last;
    logic              config_error;

    modport source (output valid, output dac_code, output frame_last,
                    output config_error, input ready);
    modport sink   (input valid, input dac_code, input frame_last,
                    input config_error, output ready);
endinterface

[hdl/wrg_cfg.sv]
// ----------------------------------------------------------------------------
// Windowed ramp generator configuration registers
// Holds the register file and derives the configuration validity flag.
// ----------------------------------------------------------------------------
module wrg_cfg import wrg_pkg::*;
#(
    parameter int MAX_SAMPLES = 16384
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMP_W-1:0]    cfg_data,
    output wrg_cfg_t             cfg,
    output logic                 cfg_ok
);

    localparam int LIM_W = 17;

    wrg_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode           <= MODE_IDLE_CODE;
            cfg_reg.min_code       <= '0;
            cfg_reg.max_code       <= '1;
            cfg_reg.idle_code      <= '0;
            cfg_reg.high_idle_code <= '1;
            cfg_reg.band_width     <= CODE_W'(1);
            cfg_reg.window_samples <= SAMP_W'(2);
            cfg_reg.frame_samples  <= SAMP_W'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE:           cfg_reg.mode           <= cfg_data[0];
                REG_MIN_CODE:       cfg_reg.min_code       <= cfg_data[CODE_W-1:0];
                REG_MAX_CODE:       cfg_reg.max_code       <= cfg_data[CODE_W-1:0];
                REG_IDLE_CODE:      cfg_reg.idle_code      <= cfg_data[CODE_W-1:0];
                REG_HIGH_IDLE_CODE: cfg_reg.high_idle_code <= cfg_data[CODE_W-1:0];
                REG_BAND_WIDTH:     cfg_reg.band_width     <= cfg_data[CODE_W-1:0];
                REG_WINDOW_SAMPLES: cfg_reg.window_samples <= cfg_data;
                REG_FRAME_SAMPLES:  cfg_reg.frame_samples  <= cfg_data;
                default:            ;
            endcase
        end
    end

    logic [CODE_W:0] low_top;
    logic [CODE_W:0] high_top;
    logic            base_ok;
    logic            band_ok;

    always_comb
    begin
        low_top  = {1'b0, cfg_reg.idle_code} + {1'b0, cfg_reg.band_width};
        high_top = {1'b0, cfg_reg.max_code} + {1'b0, cfg_reg.band_width};
        base_ok  = (cfg_reg.window_samples >= SAMP_W'(2))
                && (cfg_reg.window_samples <= cfg_reg.frame_samples)
                && (LIM_W'(cfg_reg.frame_samples) <= LIM_W'(MAX_SAMPLES))
                && (cfg_reg.min_code <= cfg_reg.max_code);
        band_ok  = (cfg_reg.band_width != '0)
                && (low_top <= {1'b0, cfg_reg.min_code})
                && (high_top <= {1'b0, cfg_reg.high_idle_code});
        cfg_ok   = base_ok && ((cfg_reg.mode == MODE_IDLE_CODE) || band_ok);
    end

    assign cfg = cfg_reg;

endmodule

[hdl/wrg_div.sv]
// ----------------------------------------------------------------------------
// Windowed ramp generator divider
// Restoring shift-subtract divider, one quotient bit per cycle, for
// quotients known to fit in the code width.
// ----------------------------------------------------------------------------
module wrg_div import wrg_pkg::*;
#(
    parameter int DEN_W  = 14,
    parameter int PROD_W = 26
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [DEN_W-1:0]  divisor,
    output logic [Q_W-1:0]    quotient,
    output wrg_div_stat_t     stat
);

    localparam int CNT_W = $clog2(Q_W);

    logic [PROD_W-1:0] rem_reg;
    logic [PROD_W-1:0] den_reg;
    logic [Q_W-1:0]    q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              fits;

    // The divisor is aligned so that the first trial tests the top quotient bit.
    assign fits = rem_reg >= den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            den_reg <= PROD_W'(divisor) << (Q_W - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - den_reg;
            end
            q_reg   <= {q_reg[Q_W-2:0], fits};
            den_reg <= den_reg >> 1;
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    always_ff @(posedge clk)
    begin
        if (rst_n && busy_reg && start)
        begin
            $error("wrg_div: start while a division is in progress");
        end
    end

endmodule

[hdl/windowed_ramp_generator.sv]
// ----------------------------------------------------------------------------
// Windowed ramp generator
// Gives one 12-bit DAC code per sample tick: a linear ramp over the window,
// then an idle code or cycling edge bands for the rest of the frame.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                Transfer when
//  in_ch     sink       restart                                valid && ready
//  out_ch    source     dac_code, frame_last, config_error     valid && ready
//  cfg_*     input      cfg_index, cfg_data                    cfg_we high
//
// A tick that lands in the ramp is offered after these steps, in order, from its
// input transfer: the product is registered, the divider is loaded, the divider
// works through the bits of the 12-bit quotient, the divider reports that it
// has finished and the code moves into the output register. Ticks outside the
// ramp, and ticks under an invalid configuration, go from the idle state
// straight to the hold state and are offered from there. The input is ready
// again in the cycle in which the result is offered. If the output register
// still holds an untaken result, the finished code waits in the sequencer and
// the input stays stalled until it moves on.
// Reset is asynchronous and active low; it restores the register defaults and
// clears the frame position and band phase. No clearing pass is needed.
//
module windowed_ramp_generator import wrg_pkg::*;
#(
    parameter int MAX_SAMPLES = 16384
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMP_W-1:0]    cfg_data,
    wrg_in_if.sink               in_ch,
    wrg_out_if.source            out_ch
);

    // The frame position never reaches MAX_SAMPLES, so this width holds it.
    localparam int IDX_W  = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CMP_W  = ((IDX_W > SAMP_W) ? IDX_W : SAMP_W) + 1;
    localparam int PROD_W = CODE_W + IDX_W;

    wrg_cfg_t      cfg;
    logic          cfg_ok;
    wrg_div_stat_t div_stat;
    logic [Q_W-1:0] quotient;

    wrg_cfg #(.MAX_SAMPLES(MAX_SAMPLES)) u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .cfg_ok    (cfg_ok)
    );

    // Sequencer and frame state.
    wrg_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CODE_W-1:0] phase_reg, phase_next;

    // Work registers for the tick in flight.
    logic [IDX_W-1:0]  work_idx_reg, work_idx_next;
    logic [PROD_W-1:0] prod_reg;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              last_reg, last_next;
    logic              err_reg, err_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_last_reg;
    logic              out_err_reg;

    logic in_xfer;
    logic out_free;
    logic div_start;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign div_start   = (state_reg == S_LOAD);

    // Per-tick decisions, all worked out in the transfer cycle. A restart
    // clears the position first; a phase beyond the band is taken as zero.
    logic [IDX_W-1:0]  eff_idx;
    logic [CODE_W-1:0] raw_phase;
    logic [CODE_W-1:0] eff_phase;
    logic [CMP_W-1:0]  idx_ext;
    logic [CMP_W-1:0]  last_idx;
    logic [CMP_W-1:0]  high_end;
    logic [CMP_W-1:0]  next_ext;
    logic              in_ramp;
    logic              at_last;
    logic [CODE_W:0]   phase_inc;
    logic [CODE_W-1:0] band_code;

    always_comb
    begin
        eff_idx   = in_ch.restart ? '0 : idx_reg;
        raw_phase = in_ch.restart ? '0 : phase_reg;
        eff_phase = (raw_phase >= cfg.band_width) ? '0 : raw_phase;
        idx_ext   = CMP_W'(eff_idx);
        last_idx  = CMP_W'(cfg.frame_samples) - CMP_W'(1);
        high_end  = CMP_W'(cfg.window_samples)
                  + ((CMP_W'(cfg.frame_samples) - CMP_W'(cfg.window_samples)) >> 1);
        next_ext  = idx_ext + CMP_W'(1);
        in_ramp   = idx_ext < CMP_W'(cfg.window_samples);
        at_last   = idx_ext >= last_idx;
        phase_inc = {1'b0, eff_phase} + (CODE_W+1)'(1);
        if (cfg.mode == MODE_IDLE_CODE)
        begin
            band_code = cfg.idle_code;
        end
        else if (idx_ext < high_end)
        begin
            band_code = cfg.high_idle_code - cfg.band_width + CODE_W'(1) + eff_phase;
        end
        else
        begin
            band_code = cfg.idle_code + cfg.band_width - CODE_W'(1) - eff_phase;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        work_idx_next  = work_idx_reg;
        code_next      = code_reg;
        last_next      = last_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    work_idx_next = eff_idx;
                    if (!cfg_ok)
                    begin
                        idx_next   = '0;
                        phase_next = '0;
                        code_next  = '0;
                        last_next  = 1'b0;
                        err_next   = 1'b1;
                        state_next = S_HOLD;
                    end
                    else
                    begin
                        code_next = band_code;
                        last_next = at_last;
                        err_next  = 1'b0;
                        if (at_last)
                        begin
                            idx_next   = '0;
                            phase_next = '0;
                        end
                        else
                        begin
                            idx_next = next_ext[IDX_W-1:0];
                            if (in_ramp || (next_ext == high_end))
                            begin
                                phase_next = '0;
                            end
                            else if (phase_inc >= {1'b0, cfg.band_width})
                            begin
                                phase_next = '0;
                            end
                            else
                            begin
                                phase_next = phase_inc[CODE_W-1:0];
                            end
                        end
                        state_next = in_ramp ? S_MUL : S_HOLD;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    code_next  = cfg.min_code + quotient;
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_idx_reg <= work_idx_next;
        code_reg     <= code_next;
        last_reg     <= last_next;
        err_reg      <= err_next;
        if (state_reg == S_MUL)
        begin
            // The span times the position; the divider then divides by the window less one.
            prod_reg <= PROD_W'(cfg.max_code - cfg.min_code) * PROD_W'(work_idx_reg);
        end
        if ((state_reg == S_HOLD) && out_free)
        begin
            out_code_reg <= code_reg;
            out_last_reg <= last_reg;
            out_err_reg  <= err_reg;
        end
    end

    logic [SAMP_W-1:0] window_m1;
    assign window_m1 = cfg.window_samples - SAMP_W'(1);

    // The window is at most the frame here, so window-1 fits the position width.
    wrg_div #(.DEN_W(IDX_W), .PROD_W(PROD_W)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (IDX_W'(window_m1)),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.dac_code     = out_code_reg;
    assign out_ch.frame_last   = out_last_reg;
    assign out_ch.config_error = out_err_reg;

    // The divider is working whenever the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && !div_stat.done |-> div_stat.busy)
        else $error("sequencer waits on an idle divider");

    // An error result carries code 0 and no frame mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |-> (out_code_reg == '0) && !out_last_reg)
        else $error("error result with non-zero code or frame mark");

    // A transfer in always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != S_IDLE))
        else $error("input transfer did not start a tick");

    // The last tick of a frame, or an invalid configuration, rewinds the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (!cfg_ok || at_last) |=> (idx_reg == '0) && (phase_reg == '0))
        else $error("frame position not cleared");

    // A pending result is not overwritten before it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_code_reg))
        else $error("pending result lost");

endmodule
